// ----- rtl/clause_gluing_resolution_prover_defines.svh -----
// assertion macros for the clause gluing prover
// used by the top level only
`ifndef CLAUSE_GLUING_RESOLUTION_PROVER_DEFINES_SVH
`define CLAUSE_GLUING_RESOLUTION_PROVER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define CGRP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// implication whose consequent is checked in the next cycle
`define CGRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- rtl/cgrp_pkg.sv -----
// shared types and codes for the clause gluing prover
// no dependencies
`timescale 1ns / 1ps
package cgrp_pkg;
   localparam int FIELD_W = 26;
   localparam int HELD_W  = 9;

   localparam logic [1:0] KIND_PREMISE = 2'd0;
   localparam logic [1:0] KIND_GOAL    = 2'd1;
   localparam logic [1:0] KIND_RUN     = 2'd2;

   localparam logic [1:0] VERDICT_NOT_PROVED = 2'd0;
   localparam logic [1:0] VERDICT_PROVED     = 2'd1;
   localparam logic [1:0] VERDICT_OVERFLOW   = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [FIELD_W-1:0] positive_literals;
      logic [FIELD_W-1:0] negative_literals;
   } req_type;

   typedef struct packed {
      logic [1:0]        verdict;
      logic [HELD_W-1:0] clauses_held;
   } rsp_type;
endpackage

// ----- rtl/cgrp_ram.sv -----
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module cgrp_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/cgrp_glue.sv -----
// gluing test of two clauses: differ in one variable with opposite signs
// no dependencies; clause = {pos, neg}
`timescale 1ns / 1ps
module cgrp_glue #(
   parameter int NUM_VARS = 26
) (
   input  logic [2*NUM_VARS-1:0] x_clause,
   input  logic [2*NUM_VARS-1:0] y_clause,
   output logic                  glue_ok,
   output logic [2*NUM_VARS-1:0] glued
);
   logic [NUM_VARS-1:0] xp, xn, yp, yn, diff, opp;

   always_comb begin
      xp = x_clause[2*NUM_VARS-1:NUM_VARS];
      xn = x_clause[NUM_VARS-1:0];
      yp = y_clause[2*NUM_VARS-1:NUM_VARS];
      yn = y_clause[NUM_VARS-1:0];
      diff = (xp ^ yp) | (xn ^ yn);
      opp  = (xp & yn) | (xn & yp);
      glue_ok = (diff != '0) && ((diff & (diff - 1'b1)) == '0) && (opp == diff);
      glued = {xp & ~diff, xn & ~diff};
   end
endmodule

// ----- rtl/clause_gluing_resolution_prover.sv -----
// clause gluing refutation prover: a premise load writes from idle, a goal load steps
// through every variable; a run walks every clause pair, scanning the table for a
// duplicate when a pair glues; passes repeat until nothing is added, the empty clause is
// found or the table overflows. one ram read port sets the pace; result is registered.
// reset clears the clause count and the sequencer; table contents need no clearing.
`timescale 1ns / 1ps
`include "clause_gluing_resolution_prover_defines.svh"
module clause_gluing_resolution_prover #(
   parameter int MAX_CLAUSES = 256,
   parameter int NUM_VARS    = 26
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cgrp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cgrp_pkg::rsp_type rsp_data
);
   localparam int AW = $clog2(MAX_CLAUSES);
   localparam int CW = $clog2(MAX_CLAUSES + 1);
   localparam int DW = 2 * NUM_VARS;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_GOAL   = 8'b0000_0010,
      ST_LDA    = 8'b0000_0100,
      ST_LDB    = 8'b0000_1000,
      ST_CMP    = 8'b0001_0000,
      ST_SC_RD  = 8'b0010_0000,
      ST_SC_CMP = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] a_ff, a_in, b_ff, b_in, i_ff, i_in, limit_ff, limit_in;
   logic [NUM_VARS-1:0] gpos_ff, gpos_in, gneg_ff, gneg_in, bit_ff, bit_in;
   logic [DW-1:0] x_ff, x_in, cand_ff, cand_in;
   logic [1:0] verdict_ff, verdict_in;
   logic rsp_valid_ff, rsp_valid_in;
   cgrp_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic wr_en;
   logic [DW-1:0] wr_data, rd_data, glued;
   logic [AW-1:0] rd_addr;
   logic glue_ok, accept, room;
   logic [NUM_VARS-1:0] ld_pos, ld_neg;

   // pair advance
   logic [CW-1:0] cnt_after, adv_a, adv_b, adv_limit;
   logic [CW:0] b_next_x, a_two_x;
   state_type adv_state;

   cgrp_ram #(.WIDTH(DW), .DEPTH(MAX_CLAUSES)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   cgrp_glue #(.NUM_VARS(NUM_VARS)) u_glue (
      .x_clause(x_ff),
      .y_clause(rd_data),
      .glue_ok (glue_ok),
      .glued   (glued)
   );

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign room = (count_ff < CW'(MAX_CLAUSES));
   assign ld_pos = NUM_VARS'(req_data.positive_literals);
   assign ld_neg = NUM_VARS'(req_data.negative_literals) & ~ld_pos;
   assign cnt_after = count_ff + CW'(wr_en);

   always_comb begin
      b_next_x = {1'b0, b_ff} + 1'b1;
      a_two_x  = {1'b0, a_ff} + 2'd2;
      adv_a = a_ff;
      adv_b = b_ff;
      adv_limit = limit_ff;
      adv_state = ST_LDA;
      if (b_next_x < {1'b0, limit_ff}) begin
         adv_b = b_next_x[CW-1:0];
      end else if (a_two_x < {1'b0, limit_ff}) begin
         adv_a = a_ff + 1'b1;
         adv_b = a_two_x[CW-1:0];
      end else if (cnt_after == limit_ff) begin
         adv_state = ST_DONE;
      end else begin
         // start another pass over the grown table
         adv_a = '0;
         adv_b = CW'(1);
         adv_limit = cnt_after;
      end
   end

   always_comb begin
      case (state_ff)
         ST_LDA:   rd_addr = a_ff[AW-1:0];
         ST_LDB:   rd_addr = b_ff[AW-1:0];
         default:  rd_addr = i_ff[AW-1:0];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      a_in = a_ff;
      b_in = b_ff;
      i_in = i_ff;
      limit_in = limit_ff;
      gpos_in = gpos_ff;
      gneg_in = gneg_ff;
      bit_in = bit_ff;
      x_in = x_ff;
      cand_in = cand_ff;
      verdict_in = verdict_ff;
      wr_en = 1'b0;
      wr_data = cand_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  cgrp_pkg::KIND_PREMISE: begin
                     wr_en = room;
                     wr_data = {ld_pos, ld_neg};
                  end
                  cgrp_pkg::KIND_GOAL: begin
                     gpos_in = ld_pos;
                     gneg_in = ld_neg;
                     bit_in = NUM_VARS'(1);
                     state_in = ST_GOAL;
                  end
                  cgrp_pkg::KIND_RUN: begin
                     a_in = '0;
                     b_in = CW'(1);
                     limit_in = count_ff;
                     verdict_in = cgrp_pkg::VERDICT_NOT_PROVED;
                     state_in = (count_ff < CW'(2)) ? ST_DONE : ST_LDA;
                  end
                  default: ;
               endcase
            end
         end
         ST_GOAL: begin
            // negated unit clause per literal, ascending variable order
            if ((gpos_ff & bit_ff) != '0) begin
               wr_en = room;
               wr_data = {{NUM_VARS{1'b0}}, bit_ff};
            end else if ((gneg_ff & bit_ff) != '0) begin
               wr_en = room;
               wr_data = {bit_ff, {NUM_VARS{1'b0}}};
            end
            bit_in = bit_ff << 1;
            if (bit_ff[NUM_VARS-1]) begin
               state_in = ST_IDLE;
            end
         end
         ST_LDA: state_in = ST_LDB;
         ST_LDB: begin
            x_in = rd_data;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (glue_ok) begin
               cand_in = glued;
               i_in = '0;
               state_in = ST_SC_RD;
            end else begin
               a_in = adv_a;
               b_in = adv_b;
               limit_in = adv_limit;
               state_in = adv_state;
            end
         end
         ST_SC_RD: state_in = ST_SC_CMP;
         ST_SC_CMP: begin
            if (rd_data == cand_ff) begin
               a_in = adv_a;
               b_in = adv_b;
               limit_in = adv_limit;
               state_in = adv_state;
            end else if (({1'b0, i_ff} + 1'b1) < {1'b0, count_ff}) begin
               i_in = i_ff + 1'b1;
               state_in = ST_SC_RD;
            end else if (!room) begin
               verdict_in = cgrp_pkg::VERDICT_OVERFLOW;
               state_in = ST_DONE;
            end else begin
               wr_en = 1'b1;
               if (cand_ff == '0) begin
                  verdict_in = cgrp_pkg::VERDICT_PROVED;
                  state_in = ST_DONE;
               end else begin
                  a_in = adv_a;
                  b_in = adv_b;
                  limit_in = adv_limit;
                  state_in = adv_state;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.verdict = verdict_ff;
               rsp_data_in.clauses_held = cgrp_pkg::HELD_W'(count_ff);
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (wr_en) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      i_ff <= i_in;
      limit_ff <= limit_in;
      gpos_ff <= gpos_in;
      gneg_ff <= gneg_in;
      bit_ff <= bit_in;
      x_ff <= x_in;
      cand_ff <= cand_in;
      verdict_ff <= verdict_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `CGRP_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_CLAUSES), "clause count above table size")
   `CGRP_ASSERT_IMPLY(a_write_room, clock, reset, wr_en, room, "table write with no room")
   `CGRP_ASSERT_NEXT(a_clear_after_run, clock, reset, (state_ff == ST_DONE) && (state_in == ST_IDLE), (count_ff == '0) && rsp_valid, "table not cleared after run")
endmodule
